### design/dtpm_pkg.sv
// dtpm_pkg: shared types, constants and the letter decoder for the
// nucleotide trie prefix-match core. Depends on nothing.
package dtpm_pkg;

  // node pool size and derived widths
  localparam int NODE_COUNT = 4096;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int USED_W     = IDX_W + 1;
  localparam int ROW_W      = 4 * IDX_W;
  localparam int DEPTH_W    = 16;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // mode codes carried on the input selector
  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // sequence terminator
  localparam logic [7:0] SYM_END = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_TERM
  } state_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] match_length;
    logic               status;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } letter_t;

  // map A/C/G/T in either case to child slots 0..3
  function automatic letter_t letter_decode(input logic [7:0] sym);
    letter_t lt;
    lt.valid = 1'b1;
    lt.code  = 2'd0;
    case (sym)
      8'h41, 8'h61: lt.code = 2'd0;
      8'h43, 8'h63: lt.code = 2'd1;
      8'h47, 8'h67: lt.code = 2'd2;
      8'h54, 8'h74: lt.code = 2'd3;
      default:      lt.valid = 1'b0;
    endcase
    return lt;
  endfunction

endpackage

### design/dtpm_ram.sv
// dtpm_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module dtpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/dtpm_ctrl.sv
// dtpm_ctrl: walk sequencer of the trie core; reads a node row, decides,
// allocates and writes back. Uses dtpm_pkg; drives two dtpm_ram instances.
module dtpm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  // input item
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              mode,
  input  logic [7:0]              symbol,
  input  logic [7:0]              strand_bits,
  // child table port
  output logic                    child_we,
  output logic [dtpm_pkg::IDX_W-1:0] child_waddr,
  output logic [dtpm_pkg::ROW_W-1:0] child_wdata,
  output logic                    child_re,
  output logic [dtpm_pkg::IDX_W-1:0] child_raddr,
  input  logic [dtpm_pkg::ROW_W-1:0] child_rdata,
  // strand mark port
  output logic                    mark_we,
  output logic [dtpm_pkg::IDX_W-1:0] mark_waddr,
  output logic [7:0]              mark_wdata,
  output logic                    mark_re,
  output logic [dtpm_pkg::IDX_W-1:0] mark_raddr,
  input  logic [7:0]              mark_rdata,
  // result
  output logic                    res_valid,
  input  logic                    res_ready,
  output dtpm_pkg::result_t       res
);

  import dtpm_pkg::*;

  localparam logic [USED_W-1:0] NODE_LIMIT = USED_W'(NODE_COUNT);

  state_t              state, state_next;
  logic                seq_active, seq_active_next;
  logic                seq_mode, seq_mode_next;
  logic [IDX_W-1:0]    cur, cur_next;
  logic [DEPTH_W-1:0]  depth, depth_next;
  logic                stopped, stopped_next;
  logic                ovf, ovf_next;
  // current node's row is logically zero and not yet in memory
  logic                fresh, fresh_next;
  logic [USED_W-1:0]   nodes_used, nodes_used_next;
  logic                child_root_ok, child_root_ok_next;
  logic                mark_root_ok, mark_root_ok_next;
  logic [1:0]          code, code_next;
  logic [7:0]          strand, strand_next;

  // view of walk state as seen by an arriving item
  logic                start;
  logic                v_mode;
  logic [IDX_W-1:0]    v_cur;
  logic [DEPTH_W-1:0]  v_depth;
  logic                v_stopped;
  logic                v_ovf;
  logic                v_fresh;
  letter_t             lt;

  // step evaluation
  logic [ROW_W-1:0]    row;
  logic [ROW_W-1:0]    row_upd;
  logic [IDX_W-1:0]    child;
  logic                missing;
  logic [IDX_W-1:0]    new_node;
  logic [DEPTH_W-1:0]  depth_inc;
  logic [7:0]          mark_old;

  assign start     = !seq_active;
  assign v_mode    = start ? (mode == MODE_INSERT) : seq_mode;
  assign v_cur     = start ? '0 : cur;
  assign v_depth   = start ? '0 : depth;
  assign v_stopped = start ? 1'b0 : stopped;
  assign v_ovf     = start ? 1'b0 : ovf;
  assign v_fresh   = start ? !child_root_ok : fresh;
  assign lt        = letter_decode(symbol);

  // child selection and row update for the pending letter
  assign row      = fresh ? '0 : child_rdata;
  assign child    = row[code*IDX_W +: IDX_W];
  assign missing  = (child == '0) || ({1'b0, child} >= NODE_LIMIT);
  assign new_node = nodes_used[IDX_W-1:0];
  assign depth_inc = (depth == DEPTH_MAX) ? depth : depth + DEPTH_W'(1);
  assign mark_old = ((cur == '0) && !mark_root_ok) ? 8'h00 : mark_rdata;

  always_comb begin
    row_upd = row;
    row_upd[code*IDX_W +: IDX_W] = new_node;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seq_active    <= 1'b0;
      seq_mode      <= 1'b0;
      cur           <= '0;
      depth         <= '0;
      stopped       <= 1'b0;
      ovf           <= 1'b0;
      fresh         <= 1'b1;
      nodes_used    <= USED_W'(1);
      child_root_ok <= 1'b0;
      mark_root_ok  <= 1'b0;
    end else begin
      state         <= state_next;
      seq_active    <= seq_active_next;
      seq_mode      <= seq_mode_next;
      cur           <= cur_next;
      depth         <= depth_next;
      stopped       <= stopped_next;
      ovf           <= ovf_next;
      fresh         <= fresh_next;
      nodes_used    <= nodes_used_next;
      child_root_ok <= child_root_ok_next;
      mark_root_ok  <= mark_root_ok_next;
    end
  end

  // item payload latches
  always_ff @(posedge clk) begin
    code   <= code_next;
    strand <= strand_next;
  end

  // next state, memory control and result
  always_comb begin
    state_next         = state;
    seq_active_next    = seq_active;
    seq_mode_next      = seq_mode;
    cur_next           = cur;
    depth_next         = depth;
    stopped_next       = stopped;
    ovf_next           = ovf;
    fresh_next         = fresh;
    nodes_used_next    = nodes_used;
    child_root_ok_next = child_root_ok;
    mark_root_ok_next  = mark_root_ok;
    code_next          = code;
    strand_next        = strand;

    in_ready    = 1'b0;
    child_we    = 1'b0;
    child_waddr = cur;
    child_wdata = row_upd;
    child_re    = 1'b0;
    child_raddr = v_cur;
    mark_we     = 1'b0;
    mark_waddr  = cur;
    mark_wdata  = mark_old | strand;
    mark_re     = 1'b0;
    mark_raddr  = v_cur;
    res_valid   = 1'b0;
    res.match_length = depth;
    res.status  = (seq_mode && ovf) ? STATUS_FULL : STATUS_OK;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (start && (mode == MODE_CLEAR)) begin
            // clear: pool back to the root alone
            nodes_used_next    = USED_W'(1);
            child_root_ok_next = 1'b0;
            mark_root_ok_next  = 1'b0;
            seq_mode_next      = 1'b0;
            cur_next           = '0;
            depth_next         = '0;
            stopped_next       = 1'b0;
            ovf_next           = 1'b0;
            fresh_next         = 1'b1;
          end else begin
            seq_active_next = 1'b1;
            seq_mode_next   = v_mode;
            cur_next        = v_cur;
            depth_next      = v_depth;
            stopped_next    = v_stopped;
            ovf_next        = v_ovf;
            fresh_next      = v_fresh;
            strand_next     = strand_bits;
            if (symbol == SYM_END) begin
              mark_re    = 1'b1;
              state_next = ST_TERM;
            end else if (!v_stopped) begin
              if (!lt.valid) begin
                // query stops on a bad letter, insert skips it
                if (!v_mode) begin
                  stopped_next = 1'b1;
                end
              end else begin
                child_re   = 1'b1;
                code_next  = lt.code;
                state_next = ST_STEP;
              end
            end
          end
        end
      end

      ST_STEP: begin
        state_next = ST_IDLE;
        if (!missing) begin
          cur_next   = child;
          fresh_next = 1'b0;
          depth_next = depth_inc;
        end else if (!seq_mode) begin
          stopped_next = 1'b1;
        end else if (nodes_used >= NODE_LIMIT) begin
          ovf_next     = 1'b1;
          stopped_next = 1'b1;
        end else begin
          // allocate: link into parent row, zero the new node's marks
          child_we        = 1'b1;
          mark_we         = 1'b1;
          mark_waddr      = new_node;
          mark_wdata      = 8'h00;
          nodes_used_next = nodes_used + USED_W'(1);
          cur_next        = new_node;
          fresh_next      = 1'b1;
          depth_next      = depth_inc;
          if (cur == '0) begin
            child_root_ok_next = 1'b1;
          end
        end
      end

      ST_TERM: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (seq_mode) begin
            // a node still unwritten gets its zero row now
            if (fresh) begin
              child_we    = 1'b1;
              child_wdata = '0;
              fresh_next  = 1'b0;
              if (cur == '0) begin
                child_root_ok_next = 1'b1;
              end
            end
            if (!ovf) begin
              mark_we = 1'b1;
              if (cur == '0) begin
                mark_root_ok_next = 1'b1;
              end
            end
          end
          seq_active_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/dna_trie_insert_prefix_match_core.sv
// dna_trie_insert_prefix_match_core: top level of the nucleotide trie core.
// Depends on dtpm_pkg, dtpm_ram and dtpm_ctrl.
//
// Usage:
//   Input stream carries one character per transaction: s_axis_tdata holds
//   symbol (bits 7:0) and strand_bits (bits 15:8), s_axis_tuser holds mode.
//   A zero symbol ends a sequence; mode is taken from a sequence's first
//   transaction (0 query, 1 insert, 2 clear the trie, 3 acts as query).
//   Output stream gives one transaction per terminator: m_axis_tdata holds
//   match_length, m_axis_tuser holds status (1 = pool full during insert).
// Steps:
//   a letter gets a node row read, then a decide step that writes back to
//   the child table when an insert allocates a node; a terminator gets a
//   strand mark read, then write back on insert; clear, skipped and
//   ignored letters are handled as they are accepted, with no further step.
// Output:
//   m_axis_tvalid is registered from the result held in ST_TERM.
// Reset and stalls:
//   reset leaves the pool holding only the root, ready at once, no clearing
//   pass. The output register lets a new item enter while a result waits;
//   a terminator that finds the register still full waits for it to drain.
module dna_trie_insert_prefix_match_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // symbol[7:0], strand_bits[15:8]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // match_length[15:0]
  output logic [0:0]  m_axis_tuser   // status[0]
);

  import dtpm_pkg::*;

  logic             child_we;
  logic [IDX_W-1:0] child_waddr;
  logic [ROW_W-1:0] child_wdata;
  logic             child_re;
  logic [IDX_W-1:0] child_raddr;
  logic [ROW_W-1:0] child_rdata;
  logic             mark_we;
  logic [IDX_W-1:0] mark_waddr;
  logic [7:0]       mark_wdata;
  logic             mark_re;
  logic [IDX_W-1:0] mark_raddr;
  logic [7:0]       mark_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid;
  result_t          out_res;

  // child index table, four slots per node
  dtpm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_COUNT)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .re    (child_re),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  // strand marks per node
  dtpm_ram #(
    .WIDTH (8),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  dtpm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .mode        (s_axis_tuser),
    .symbol      (s_axis_tdata[7:0]),
    .strand_bits (s_axis_tdata[15:8]),
    .child_we    (child_we),
    .child_waddr (child_waddr),
    .child_wdata (child_wdata),
    .child_re    (child_re),
    .child_raddr (child_raddr),
    .child_rdata (child_rdata),
    .mark_we     (mark_we),
    .mark_waddr  (mark_waddr),
    .mark_wdata  (mark_wdata),
    .mark_re     (mark_re),
    .mark_raddr  (mark_raddr),
    .mark_rdata  (mark_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_res.match_length;
  assign m_axis_tuser[0] = out_res.status;

`ifndef NO_ASSERTIONS
  // memories are written only while an item is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (child_we || mark_we) |-> !s_axis_tready)
    else $error("memory write while idle");

  // a child row read is always followed by its decision cycle
  a_read_step: assert property (@(posedge clk) disable iff (rst)
    child_re |=> (!child_re && !s_axis_tready))
    else $error("child read not followed by step");

  // a pending result is held until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("pending result dropped");

  // output valid rises only from a pending result
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(res_valid))
    else $error("output without result");
`endif

endmodule
